### hdl/sfrs_pkg.sv
// shared types and constants for the sensor fault repair and statistics block
// no dependencies; imported by every module of the block
`default_nettype none

package sfrs_pkg;

  // fixed field widths
  localparam int SAMPLE_W  = 16;
  localparam int CNT_W     = 16;
  localparam int SUM_W     = 32;
  localparam int AVG_W     = 24;
  localparam int FRAC_W    = 8;
  localparam int DIVD_W    = SUM_W + FRAC_W;
  localparam int DIV_STEPS = DIVD_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 1;

  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // register reset values
  localparam logic [SAMPLE_W-1:0] FAULT_CODE_RST = 16'hFF9D;  // -99
  localparam logic [CNT_W-1:0]    THRESHOLD_RST  = 16'd35;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT_CODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_EMIT,
    S_DIV_GO,
    S_DIV_WAIT,
    S_LAST
  } sfrs_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic ld_item;
    logic fault_inc;
    logic pend_inc;
    logic set_ovf;
    logic emit_setup;
    logic burst;
    logic set_seen;
    logic do_emit;
    logic out_load;
    logic left_dec;
    logic div_start;
    logic out_load_last;
    logic clear_log;
  } sfrs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_fault;
    logic seen_valid;
    logic pend_full;
    logic eol;
    logic left_zero;
    logic out_free;
  } sfrs_sts_t;

endpackage

`default_nettype wire

### hdl/sfrs_div.sv
// iterative restoring divider for the q8 mean, one quotient bit per cycle
// depends on sfrs_pkg
`default_nettype none

module sfrs_div
  import sfrs_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] sum_i,
  input  wire logic        [CNT_W-1:0] count_i,
  output logic                         done_o,
  output logic             [AVG_W-1:0] avg_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic [CNT_W-1:0]  dvsr_q, dvsr_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [DIVD_W-1:0] dvd_q, dvd_d;

  logic [SUM_W-1:0]  mag;
  logic [CNT_W:0]    trial;
  logic              qbit;
  logic [AVG_W-1:0]  quo;

  // magnitude of the sum and one restoring step
  assign mag   = sum_i[SUM_W-1] ? (~sum_i + 1'b1) : sum_i;
  assign trial = {rem_q[CNT_W-1:0], dvd_q[DIVD_W-1]};
  assign qbit  = (trial >= {1'b0, dvsr_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    dvsr_d = dvsr_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      neg_d  = sum_i[SUM_W-1];
      zero_d = (count_i == '0);
      dvsr_d = count_i;
      rem_d  = '0;
      dvd_d  = {mag, {FRAC_W{1'b0}}};
    end else if (busy_q) begin
      rem_d  = qbit ? (trial - {1'b0, dvsr_q}) : trial;
      dvd_d  = {dvd_q[DIVD_W-2:0], qbit};
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    zero_q <= zero_d;
    dvsr_q <= dvsr_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
  end

  // sign restore, truncation toward zero falls out of magnitude division
  assign quo    = dvd_q[AVG_W-1:0];
  assign avg_o  = zero_q ? '0 : (neg_q ? (~quo + 1'b1) : quo);
  assign done_o = done_q;

endmodule

`default_nettype wire

### hdl/sfrs_ctrl.sv
// controller state machine: sequences hold, emit bursts, mean division and final word
// depends on sfrs_pkg
`default_nettype none

module sfrs_ctrl
  import sfrs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire sfrs_sts_t sts_i,
  input  wire logic      div_done_i,
  output sfrs_cmd_t      cmd_o
);

  sfrs_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld_item = 1'b1;
          state_d       = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.fault_inc = 1'b1;
        if (sts_i.seen_valid) begin
          // hold last value on a fault, pass a good sample
          cmd_o.emit_setup = 1'b1;
          state_d          = S_EMIT;
        end else if (sts_i.is_fault && !sts_i.eol && !sts_i.pend_full) begin
          // leading fault goes into the hold
          cmd_o.pend_inc = 1'b1;
          state_d        = S_IDLE;
        end else if (sts_i.is_fault && !sts_i.eol) begin
          // hold is full: this fault leaves unrepaired
          cmd_o.set_ovf    = 1'b1;
          cmd_o.emit_setup = 1'b1;
          state_d          = S_EMIT;
        end else begin
          // release the held faults as copies, then the sample
          cmd_o.emit_setup = 1'b1;
          cmd_o.burst      = 1'b1;
          cmd_o.set_seen   = !sts_i.is_fault;
          state_d          = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts_i.left_zero && sts_i.eol) begin
          // final value updates stats now, word goes out after the mean
          cmd_o.do_emit = 1'b1;
          state_d       = S_DIV_GO;
        end else if (sts_i.out_free) begin
          cmd_o.do_emit  = 1'b1;
          cmd_o.out_load = 1'b1;
          if (sts_i.left_zero) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.left_dec = 1'b1;
          end
        end
      end
      S_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done_i) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        if (sts_i.out_free) begin
          cmd_o.out_load_last = 1'b1;
          cmd_o.clear_log     = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/sfrs_dp.sv
// datapath: config registers, log state, per-value statistics and output register
// depends on sfrs_pkg
`default_nettype none

module sfrs_dp
  import sfrs_pkg::*;
#(
  parameter int MAX_LEADING_RUN = 63,
  parameter int PEND_W          = 6
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic       [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [SAMPLE_W-1:0] cfg_data_i,
  // input word
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       end_of_log_i,
  // control
  input  wire sfrs_cmd_t                  cmd_i,
  output sfrs_sts_t                       sts_o,
  // divider
  output logic signed         [SUM_W-1:0] sum_o,
  output logic                [CNT_W-1:0] count_o,
  input  wire logic           [AVG_W-1:0] avg_i,
  // output word
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed      [SAMPLE_W-1:0] repaired_o,
  output logic                            last_of_log_o,
  output logic                [CNT_W-1:0] fault_total_o,
  output logic                [CNT_W-1:0] jump_count_o,
  output logic signed         [AVG_W-1:0] average_q8_o,
  output logic                            leading_overflow_o
);

  logic [SAMPLE_W-1:0] fault_code_q;
  logic [CNT_W-1:0]    thresh_q;

  logic [SAMPLE_W-1:0] sample_q;
  logic                eol_q;

  logic                seen_q;
  logic                ovf_q;
  logic [PEND_W-1:0]   pend_q;
  logic [PEND_W-1:0]   left_q;
  logic [SAMPLE_W-1:0] emit_val_q;
  logic [SAMPLE_W-1:0] prev_q;
  logic [CNT_W-1:0]    fault_cnt_q;
  logic [CNT_W-1:0]    change_cnt_q;
  logic [CNT_W-1:0]    sample_cnt_q;
  logic [SUM_W-1:0]    sum_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_rep_q;
  logic                out_last_q;
  logic [CNT_W-1:0]    out_fault_q;
  logic [CNT_W-1:0]    out_change_q;
  logic [AVG_W-1:0]    out_avg_q;
  logic                out_ovf_q;

  logic                is_fault;
  logic                out_free;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   abs_diff;
  logic                big_step;

  // configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fault_code_q <= FAULT_CODE_RST;
      thresh_q     <= THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FAULT_CODE: fault_code_q <= cfg_data_i;
        CFG_THRESHOLD:  thresh_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_item) begin
      sample_q <= sample_i;
      eol_q    <= end_of_log_i;
    end
  end

  assign is_fault = (sample_q == fault_code_q);
  assign out_free = !out_valid_q || out_ready_i;

  // step size between consecutive emitted values
  assign diff     = {emit_val_q[SAMPLE_W-1], emit_val_q} - {prev_q[SAMPLE_W-1], prev_q};
  assign abs_diff = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign big_step = (abs_diff > {1'b0, thresh_q});

  // log control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      ovf_q  <= 1'b0;
      pend_q <= '0;
      left_q <= '0;
    end else if (cmd_i.clear_log) begin
      seen_q <= 1'b0;
      ovf_q  <= 1'b0;
      pend_q <= '0;
      left_q <= '0;
    end else begin
      if (cmd_i.set_seen) begin
        seen_q <= 1'b1;
      end
      if (cmd_i.set_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.pend_inc) begin
        pend_q <= pend_q + 1'b1;
      end else if (cmd_i.emit_setup && cmd_i.burst) begin
        pend_q <= '0;
      end
      if (cmd_i.emit_setup) begin
        left_q <= cmd_i.burst ? pend_q : '0;
      end else if (cmd_i.left_dec) begin
        left_q <= left_q - 1'b1;
      end
    end
  end

  // value to emit: held last value on a fault once a good sample was seen
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_setup) begin
      emit_val_q <= (seen_q && is_fault) ? prev_q : sample_q;
    end
  end

  // statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= '0;
      fault_cnt_q  <= '0;
      change_cnt_q <= '0;
      sample_cnt_q <= '0;
      sum_q        <= '0;
    end else if (cmd_i.clear_log) begin
      prev_q       <= '0;
      fault_cnt_q  <= '0;
      change_cnt_q <= '0;
      sample_cnt_q <= '0;
      sum_q        <= '0;
    end else begin
      if (cmd_i.fault_inc && is_fault && (fault_cnt_q != CNT_SAT)) begin
        fault_cnt_q <= fault_cnt_q + 1'b1;
      end
      if (cmd_i.do_emit) begin
        prev_q <= emit_val_q;
        if ((sample_cnt_q != '0) && big_step && (change_cnt_q != CNT_SAT)) begin
          change_cnt_q <= change_cnt_q + 1'b1;
        end
        if (sample_cnt_q != CNT_SAT) begin
          sum_q        <= sum_q + {{(SUM_W-SAMPLE_W){emit_val_q[SAMPLE_W-1]}}, emit_val_q};
          sample_cnt_q <= sample_cnt_q + 1'b1;
        end
      end
    end
  end

  assign sum_o   = sum_q;
  assign count_o = sample_cnt_q;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load || cmd_i.out_load_last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_rep_q    <= emit_val_q;
      out_last_q   <= 1'b0;
      out_fault_q  <= '0;
      out_change_q <= '0;
      out_avg_q    <= '0;
      out_ovf_q    <= 1'b0;
    end else if (cmd_i.out_load_last) begin
      out_rep_q    <= prev_q;
      out_last_q   <= 1'b1;
      out_fault_q  <= fault_cnt_q;
      out_change_q <= change_cnt_q;
      out_avg_q    <= avg_i;
      out_ovf_q    <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign repaired_o         = out_rep_q;
  assign last_of_log_o      = out_last_q;
  assign fault_total_o      = out_fault_q;
  assign jump_count_o       = out_change_q;
  assign average_q8_o       = out_avg_q;
  assign leading_overflow_o = out_ovf_q;

  // status to controller
  assign sts_o.is_fault   = is_fault;
  assign sts_o.seen_valid = seen_q;
  assign sts_o.pend_full  = (pend_q == PEND_W'(MAX_LEADING_RUN));
  assign sts_o.eol        = eol_q;
  assign sts_o.left_zero  = (left_q == '0);
  assign sts_o.out_free   = out_free;

  // checks
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= PEND_W'(MAX_LEADING_RUN))
    else $error("leading hold count beyond limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load || cmd_i.out_load_last) |-> out_free)
    else $error("output word overwritten before it was taken");

  a_stats_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_last_q) |->
      (out_fault_q == '0 && out_change_q == '0 && out_avg_q == '0 && !out_ovf_q))
    else $error("statistics on a word that does not end the log");

  a_last_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (sample_cnt_q != '0))
    else $error("mean started with no values counted");

endmodule

`default_nettype wire

### hdl/sensor_fault_repair_stats.sv
// Sensor fault repair with per-log statistics.
// Input channel (in_valid_i/in_ready_o) takes one signed sample word and an
// end-of-log flag. A sample equal to the fault code is replaced by the last
// emitted value. Faults before the first good sample of a log are held
// (up to MAX_LEADING_RUN) and released as copies of that sample; an over-long
// leading run sets the overflow flag and faults beyond the hold pass unrepaired.
// Output channel (out_valid_o/out_ready_i) gives one word per emitted value;
// the word that ends a log carries fault count, large-step count, q8 mean
// and overflow flag, all zero on other words.
// Configuration channel writes fault code (index 0) and change threshold
// (index 1); always ready. The user must keep it written only while the block
// is idle; the block itself does not enforce this.
// An item with one result passes accept, evaluate and emit; a held leading
// fault passes accept and evaluate; a release of held faults emits each
// held copy, then the sample. The last item of a log also waits for the
// mean from a restoring divider that makes one quotient bit per cycle over 40 bits.
// Reset loads the default fault code and threshold and clears the log state.
// A stalled receiver holds the output register; the block then waits at its
// next emit step, and takes no new item until that word is placed.
`default_nettype none

module sensor_fault_repair_stats
  import sfrs_pkg::*;
#(
  parameter int MAX_LEADING_RUN = 63
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration channel
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic       [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic        [SAMPLE_W-1:0] cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       end_of_log_i,
  // output channel
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic signed      [SAMPLE_W-1:0] repaired_o,
  output logic                            last_of_log_o,
  output logic                [CNT_W-1:0] fault_total_o,
  output logic                [CNT_W-1:0] jump_count_o,
  output logic signed         [AVG_W-1:0] average_q8_o,
  output logic                            leading_overflow_o
);

  localparam int PEND_W = $clog2(MAX_LEADING_RUN + 1);

  sfrs_cmd_t         cmd;
  sfrs_sts_t         sts;
  logic              div_done;
  logic [AVG_W-1:0]  avg;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;

  // controller
  sfrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .div_done_i (div_done),
    .cmd_o      (cmd)
  );

  // datapath
  sfrs_dp #(
    .MAX_LEADING_RUN (MAX_LEADING_RUN),
    .PEND_W          (PEND_W)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .sample_i           (sample_i),
    .end_of_log_i       (end_of_log_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .sum_o              (sum),
    .count_o            (count),
    .avg_i              (avg),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .repaired_o         (repaired_o),
    .last_of_log_o      (last_of_log_o),
    .fault_total_o      (fault_total_o),
    .jump_count_o       (jump_count_o),
    .average_q8_o       (average_q8_o),
    .leading_overflow_o (leading_overflow_o)
  );

  // mean divider
  sfrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd.div_start),
    .sum_i   (sum),
    .count_i (count),
    .done_o  (div_done),
    .avg_o   (avg)
  );

endmodule

`default_nettype wire
